// ===== rtl/sacl_pkg.sv =====
// Shared constants, register codes and state type of the cache LRU directory.
package sacl_pkg;

    localparam int DEF_MAX_WAYS   = 4;
    localparam int DEF_MAX_SETS   = 1024;
    localparam int DEF_ADDR_BITS  = 32;
    localparam int DEF_COUNT_BITS = 32;

    localparam int ADDR_W     = 32;
    localparam int WAY_OUT_W  = 2;
    localparam int SET_OUT_W  = 10;
    localparam int CNT_OUT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    localparam logic [3:0] RST_LINE_SHIFT = 4'd4;
    localparam logic [3:0] RST_SET_SHIFT  = 4'd10;
    localparam logic [2:0] RST_WAYS_USED  = 3'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_WRITE
    } sacl_state_t;

endpackage

// ===== rtl/sacl_req_if.sv =====
// Request channel: operation and byte address.
interface sacl_req_if;
    import sacl_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

// ===== rtl/sacl_rsp_if.sv =====
// Response channel: hit/miss, way, set and running counters.
interface sacl_rsp_if;
    import sacl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 miss;
    logic [WAY_OUT_W-1:0] way_hit_or_filled;
    logic [SET_OUT_W-1:0] set_selected;
    logic [CNT_OUT_W-1:0] accesses_so_far;
    logic [CNT_OUT_W-1:0] misses_so_far;

    modport source (output valid, output miss, output way_hit_or_filled,
                    output set_selected, output accesses_so_far,
                    output misses_so_far, input ready);
    modport sink   (input valid, input miss, input way_hit_or_filled,
                    input set_selected, input accesses_so_far,
                    input misses_so_far, output ready);
endinterface

// ===== rtl/sacl_cfg_if.sv =====
// Configuration write channel: register index and data.
interface sacl_cfg_if;
    import sacl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sacl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/set_assoc_cache_lru_directory.sv =====
// Set-associative cache tag directory with timestamp LRU replacement.
//
//  channel | dir | fields                                           | accepted when
//  req     | in  | operation, address                               | valid & ready
//  rsp     | out | miss, way_hit_or_filled, set_selected, counters  | valid & ready
//  cfg     | in  | index, data (line_shift, set_shift, ways_used)   | valid & ready
//
// One set row (all ways: valid, tag, stamp) lives in one RAM word.
// Access: accept (IDLE), lookup (LOOK), write back (WRITE); a miss on a full set
// adds a stamp scan (SCAN) when more than one way is used. Flush: sweep of all rows, then result.
// After reset a sweep of all MAX_SETS rows zeroes the RAM; req.ready stays low.
// The write-back stage waits while the result register is full and unread.
module set_assoc_cache_lru_directory #(
    parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS   = sacl_pkg::DEF_MAX_SETS,
    parameter int ADDR_BITS  = sacl_pkg::DEF_ADDR_BITS,
    parameter int COUNT_BITS = sacl_pkg::DEF_COUNT_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    sacl_req_if.sink   req,
    sacl_rsp_if.source rsp,
    sacl_cfg_if.sink   cfg
);
    import sacl_pkg::*;

    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LOG  = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_BITS = 1 + ADDR_BITS + COUNT_BITS;
    localparam int ROW_W    = MAX_WAYS * WAY_BITS;
    localparam logic [ADDR_BITS-1:0] ONE_A = 1;

    sacl_state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                  flush_reg, flush_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [ADDR_BITS-1:0]  tag_reg, tag_next;
    logic [WAY_W-1:0]      pick_reg, pick_next;
    logic                  miss_reg, miss_next;
    logic [WAY_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] mis_reg, mis_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;

    logic                  out_miss_reg, out_miss_next;
    logic [WAY_OUT_W-1:0]  out_way_reg, out_way_next;
    logic [SET_OUT_W-1:0]  out_set_reg, out_set_next;
    logic [CNT_OUT_W-1:0]  out_acc_reg, out_acc_next;
    logic [CNT_OUT_W-1:0]  out_mis_reg, out_mis_next;

    logic [3:0] line_shift_reg;
    logic [3:0] set_shift_reg;
    logic [2:0] ways_used_reg;

    logic              ram_wr_en;
    logic [SET_W-1:0]  ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [SET_W-1:0]  ram_rd_addr;
    logic [ROW_W-1:0]  ram_rd_data;

    logic                  way_valid [MAX_WAYS];
    logic [ADDR_BITS-1:0]  way_tag   [MAX_WAYS];
    logic [COUNT_BITS-1:0] way_stamp [MAX_WAYS];

    logic [NW_W-1:0]      nways;
    logic [3:0]           sbits;
    logic [ADDR_BITS-1:0] addr_w;
    logic [ADDR_BITS-1:0] line_w;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic                 any_free;
    logic [WAY_W-1:0]     free_way;
    logic [ROW_W-1:0]     new_row;
    logic [COUNT_BITS-1:0] acc_inc;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_shift_reg <= RST_LINE_SHIFT;
            set_shift_reg  <= RST_SET_SHIFT;
            ways_used_reg  <= RST_WAYS_USED;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LINE_SHIFT: line_shift_reg <= cfg.data;
                CFG_SET_SHIFT:  set_shift_reg  <= cfg.data;
                CFG_WAYS_USED:  ways_used_reg  <= cfg.data[2:0];
                default:        ;
            endcase
        end
    end

    // effective geometry
    always_comb
    begin
        if (ways_used_reg == 3'd0)
        begin
            nways = NW_W'(1);
        end
        else if (int'(ways_used_reg) > MAX_WAYS)
        begin
            nways = NW_W'(MAX_WAYS);
        end
        else
        begin
            nways = NW_W'(ways_used_reg);
        end
        sbits  = (int'(set_shift_reg) > SET_LOG) ? 4'(SET_LOG) : set_shift_reg;
        addr_w = ADDR_BITS'(req.address);
        line_w = addr_w >> line_shift_reg;
    end

    // unpack the row and resolve hit and first free way
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_valid[w] = ram_rd_data[w*WAY_BITS + ADDR_BITS + COUNT_BITS];
            way_tag[w]   = ram_rd_data[w*WAY_BITS + COUNT_BITS +: ADDR_BITS];
            way_stamp[w] = ram_rd_data[w*WAY_BITS +: COUNT_BITS];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < int'(nways))
            begin
                if (way_valid[w] && (way_tag[w] == tag_reg))
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!way_valid[w])
                begin
                    any_free = 1'b1;
                    free_way = WAY_W'(w);
                end
            end
        end
    end

    assign acc_inc = acc_reg + COUNT_BITS'(1);

    always_comb
    begin
        new_row = ram_rd_data;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_W'(w) == pick_reg)
            begin
                new_row[w*WAY_BITS +: WAY_BITS] = {1'b1, tag_reg, acc_inc};
            end
        end
    end

    // control
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        flush_next     = flush_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        pick_next      = pick_reg;
        miss_next      = miss_reg;
        scan_idx_next  = scan_idx_reg;
        best_next      = best_reg;
        acc_next       = acc_reg;
        mis_next       = mis_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_load       = 1'b0;
        out_miss_next  = 1'b0;
        out_way_next   = '0;
        out_set_next   = '0;
        out_acc_next   = '0;
        out_mis_next   = '0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = set_reg;
        ram_wr_data    = new_row;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = SET_W'(line_w & ((ONE_A << sbits) - ONE_A));
        req.ready      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_idx_reg;
                ram_wr_data  = '0;
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(MAX_SETS - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = flush_reg ? S_WRITE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    flush_next = req.operation;
                    if (req.operation)
                    begin
                        clr_idx_next = '0;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        set_next   = ram_rd_addr;
                        tag_next   = line_w >> sbits;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                priority if (hit)
                begin
                    pick_next  = hit_way;
                    miss_next  = 1'b0;
                    state_next = S_WRITE;
                end
                else if (any_free)
                begin
                    pick_next  = free_way;
                    miss_next  = 1'b1;
                    state_next = S_WRITE;
                end
                else
                begin
                    pick_next     = '0;
                    miss_next     = 1'b1;
                    best_next     = way_stamp[0];
                    scan_idx_next = WAY_W'(1);
                    state_next    = (nways == NW_W'(1)) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (way_stamp[scan_idx_reg] < best_reg)
                begin
                    best_next = way_stamp[scan_idx_reg];
                    pick_next = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + WAY_W'(1);
                if (NW_W'(scan_idx_reg) == nways - NW_W'(1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (flush_reg)
                    begin
                        acc_next   = '0;
                        mis_next   = '0;
                        flush_next = 1'b0;
                    end
                    else
                    begin
                        ram_wr_en     = 1'b1;
                        acc_next      = acc_inc;
                        mis_next      = mis_reg + COUNT_BITS'(miss_reg);
                        out_miss_next = miss_reg;
                        out_way_next  = WAY_OUT_W'(pick_reg);
                        out_set_next  = SET_OUT_W'(set_reg);
                        out_acc_next  = CNT_OUT_W'(acc_inc);
                        out_mis_next  = CNT_OUT_W'(mis_reg + COUNT_BITS'(miss_reg));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            flush_reg     <= 1'b0;
            acc_reg       <= '0;
            mis_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            flush_reg     <= flush_next;
            acc_reg       <= acc_next;
            mis_reg       <= mis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        pick_reg     <= pick_next;
        miss_reg     <= miss_next;
        scan_idx_reg <= scan_idx_next;
        best_reg     <= best_next;
        if (out_load)
        begin
            out_miss_reg <= out_miss_next;
            out_way_reg  <= out_way_next;
            out_set_reg  <= out_set_next;
            out_acc_reg  <= out_acc_next;
            out_mis_reg  <= out_mis_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.miss              = out_miss_reg;
    assign rsp.way_hit_or_filled = out_way_reg;
    assign rsp.set_selected      = out_set_reg;
    assign rsp.accesses_so_far   = out_acc_reg;
    assign rsp.misses_so_far     = out_mis_reg;
endmodule
